### design/acaf_pkg.sv
// shared types and constants for the actuator command ascii framer
`default_nettype none

package acaf_pkg;

    // configuration register indexes
    typedef enum logic [7:0] {
        CFG_STEERING_CENTER = 8'd0,
        CFG_STEERING_MIN    = 8'd1,
        CFG_ACCEL_MIN       = 8'd2,
        CFG_REVERSE_MIN     = 8'd3
    } cfg_index_t;

    // classified values handed from the front part to the back part
    typedef struct packed {
        logic [15:0] steer;
        logic [15:0] rev;
        logic [15:0] fwd;
    } vals_t;

    // five bcd digits per value
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = 4 * BCD_DIGITS;

    typedef struct packed {
        logic [BCD_W-1:0] steer;
        logic [BCD_W-1:0] rev;
        logic [BCD_W-1:0] fwd;
    } bcd_t;

    // queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW    = $clog2(QDEPTH + 1);

    // converter: two binary bits per step, sixteen bits
    localparam int CNV_STEPS = 8;
    localparam int CNV_CW    = $clog2(CNV_STEPS);

    typedef enum logic [1:0] {
        CNV_IDLE,
        CNV_RUN,
        CNV_DONE
    } cnv_state_t;

    // frame layout
    localparam int FRAME_LEN = 16;
    localparam int IDX_W     = $clog2(FRAME_LEN);

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_S    = 8'h73;
    localparam logic [7:0] CH_R    = 8'h72;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_NL   = 8'h0A;

endpackage

`default_nettype wire

### design/actuator_command_ascii_framer.sv
// top level of the actuator command ascii framer
//
//  channel   handshake               payload
//  -------   ---------------------   ---------------------------------------------
//  input     push / full             reverse_level, steer_right, steer_left,
//                                    forward_level, reverse_selected
//  result    empty / pop             out_byte, last_byte (high on closing newline)
//  config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// each reading set becomes a 16-byte line: 's' dddd 'r' dddd 'a' dddd newline
// one byte per cycle leaves the result register while pop is held high, and the
// byte sequencer limits the rate of reading sets; the bcd converter prepares the
// next set while a line goes out, and the front works in the sequencer's shadow
// a set goes through queue, converter and sequencer before its first byte shows
// reset clears configuration to zero and empties queue, converter and result
// a stalled result side fills the queue, then full rises; cfg_ready is always high
`default_nettype none

module actuator_command_ascii_framer (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input channel
    input  wire logic        push,
    output logic             full,
    input  wire logic [15:0] reverse_level,
    input  wire logic [15:0] steer_right,
    input  wire logic [15:0] steer_left,
    input  wire logic [15:0] forward_level,
    input  wire logic        reverse_selected,
    // result channel
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       out_byte,
    output logic             last_byte,
    // configuration channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    acaf_pkg::vals_t   front_vals;
    acaf_pkg::vals_t   q_data;
    acaf_pkg::bcd_t    cnv_bcd;
    logic              q_empty;
    logic              q_pop;
    logic              cnv_done;
    logic              cnv_take;
    logic              in_xfer;

    // an input transfer goes straight into the queue
    assign in_xfer = push && !full;

    // front: configuration and classification
    acaf_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .reverse_level    (reverse_level),
        .steer_right      (steer_right),
        .steer_left       (steer_left),
        .forward_level    (forward_level),
        .reverse_selected (reverse_selected),
        .vals             (front_vals)
    );

    // decoupling queue
    acaf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_xfer),
        .wr_data (front_vals),
        .q_full  (full),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .q_empty (q_empty)
    );

    // back: bcd conversion
    acaf_conv u_conv (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .cnv_done (cnv_done),
        .cnv_take (cnv_take),
        .cnv_bcd  (cnv_bcd)
    );

    // back: line sequencer and result register
    acaf_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cnv_done  (cnv_done),
        .cnv_bcd   (cnv_bcd),
        .cnv_take  (cnv_take),
        .empty     (empty),
        .pop       (pop),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

endmodule

`default_nettype wire

### design/acaf_front.sv
// front part: configuration registers and classification of one reading set
`default_nettype none

module acaf_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [7:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire logic [15:0]         reverse_level,
    input  wire logic [15:0]         steer_right,
    input  wire logic [15:0]         steer_left,
    input  wire logic [15:0]         forward_level,
    input  wire logic                reverse_selected,
    output acaf_pkg::vals_t          vals
);

    logic [15:0] steering_center_reg;
    logic [15:0] steering_min_reg;
    logic [15:0] accel_min_reg;
    logic [15:0] reverse_min_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steering_center_reg <= '0;
            steering_min_reg    <= '0;
            accel_min_reg       <= '0;
            reverse_min_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                acaf_pkg::CFG_STEERING_CENTER: steering_center_reg <= cfg_data;
                acaf_pkg::CFG_STEERING_MIN:    steering_min_reg    <= cfg_data;
                acaf_pkg::CFG_ACCEL_MIN:       accel_min_reg       <= cfg_data;
                acaf_pkg::CFG_REVERSE_MIN:     reverse_min_reg     <= cfg_data;
                default:                       ;
            endcase
        end
    end

    // left has priority over right
    always_comb
    begin
        if (steer_left > steering_min_reg)
            vals.steer = steering_center_reg - {1'b0, steer_left[15:1]};
        else if (steer_right > steering_min_reg)
            vals.steer = steering_center_reg + {1'b0, steer_right[15:1]};
        else
            vals.steer = steering_center_reg;

        if ((forward_level <= accel_min_reg) || reverse_selected)
            vals.fwd = '0;
        else
            vals.fwd = forward_level;

        if ((reverse_level <= reverse_min_reg) || !reverse_selected)
            vals.rev = '0;
        else
            vals.rev = reverse_level;
    end

endmodule

`default_nettype wire

### design/acaf_queue.sv
// short queue of classified values between front and back
`default_nettype none

module acaf_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire acaf_pkg::vals_t     wr_data,
    output logic                     q_full,
    input  wire logic                rd_en,
    output acaf_pkg::vals_t          rd_data,
    output logic                     q_empty
);

    acaf_pkg::vals_t                 slot_reg [acaf_pkg::QDEPTH];
    logic [acaf_pkg::QPW-1:0]        wptr_reg;
    logic [acaf_pkg::QPW-1:0]        rptr_reg;
    logic [acaf_pkg::QCW-1:0]        count_reg;

    localparam logic [acaf_pkg::QPW-1:0] PTR_LAST = acaf_pkg::QPW'(acaf_pkg::QDEPTH - 1);

    assign q_full  = (count_reg == acaf_pkg::QCW'(acaf_pkg::QDEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_data = slot_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wptr_reg <= (wptr_reg == PTR_LAST) ? '0 : wptr_reg + acaf_pkg::QPW'(1);
            if (rd_en)
                rptr_reg <= (rptr_reg == PTR_LAST) ? '0 : rptr_reg + acaf_pkg::QPW'(1);
            if (wr_en && !rd_en)
                count_reg <= count_reg + acaf_pkg::QCW'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - acaf_pkg::QCW'(1);
        end
    end

endmodule

`default_nettype wire

### design/acaf_conv.sv
// back part, first half: binary to bcd conversion of three values in parallel
`default_nettype none

module acaf_conv (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_empty,
    input  wire acaf_pkg::vals_t     q_data,
    output logic                     q_pop,
    output logic                     cnv_done,
    input  wire logic                cnv_take,
    output acaf_pkg::bcd_t           cnv_bcd
);

    acaf_pkg::cnv_state_t            state_reg;
    acaf_pkg::cnv_state_t            state_next;
    logic [acaf_pkg::CNV_CW-1:0]     cnt_reg;
    acaf_pkg::vals_t                 bin_reg;
    acaf_pkg::bcd_t                  bcd_reg;
    acaf_pkg::bcd_t                  bcd_next;

    // one double-dabble step: add 3 to digits of 5 or more, then shift in a bit
    function automatic logic [acaf_pkg::BCD_W-1:0] dabble(
        input logic [acaf_pkg::BCD_W-1:0] b,
        input logic                       bit_in
    );
        logic [acaf_pkg::BCD_W-1:0] adj;
        adj = b;
        for (int d = 0; d < acaf_pkg::BCD_DIGITS; d++)
        begin
            if (adj[d*4 +: 4] >= 4'd5)
                adj[d*4 +: 4] = adj[d*4 +: 4] + 4'd3;
        end
        return {adj[acaf_pkg::BCD_W-2:0], bit_in};
    endfunction

    assign cnv_bcd = bcd_reg;

    // outputs
    always_comb
    begin
        q_pop    = 1'b0;
        cnv_done = 1'b0;
        case (state_reg)
            acaf_pkg::CNV_IDLE: q_pop = !q_empty;
            acaf_pkg::CNV_DONE:
            begin
                cnv_done = 1'b1;
                q_pop    = cnv_take && !q_empty;
            end
            default: ;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            acaf_pkg::CNV_IDLE:
                if (q_pop)
                    state_next = acaf_pkg::CNV_RUN;
            acaf_pkg::CNV_RUN:
                if (cnt_reg == acaf_pkg::CNV_CW'(acaf_pkg::CNV_STEPS - 1))
                    state_next = acaf_pkg::CNV_DONE;
            acaf_pkg::CNV_DONE:
                if (cnv_take)
                    state_next = q_pop ? acaf_pkg::CNV_RUN : acaf_pkg::CNV_IDLE;
            default:
                state_next = acaf_pkg::CNV_IDLE;
        endcase
    end

    // two bits per cycle on each lane
    always_comb
    begin
        bcd_next.steer = dabble(dabble(bcd_reg.steer, bin_reg.steer[15]), bin_reg.steer[14]);
        bcd_next.rev   = dabble(dabble(bcd_reg.rev, bin_reg.rev[15]), bin_reg.rev[14]);
        bcd_next.fwd   = dabble(dabble(bcd_reg.fwd, bin_reg.fwd[15]), bin_reg.fwd[14]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acaf_pkg::CNV_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
                cnt_reg <= '0;
            else if (state_reg == acaf_pkg::CNV_RUN)
                cnt_reg <= cnt_reg + acaf_pkg::CNV_CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            bin_reg <= q_data;
            bcd_reg <= '0;
        end
        else if (state_reg == acaf_pkg::CNV_RUN)
        begin
            bin_reg.steer <= {bin_reg.steer[13:0], 2'b00};
            bin_reg.rev   <= {bin_reg.rev[13:0], 2'b00};
            bin_reg.fwd   <= {bin_reg.fwd[13:0], 2'b00};
            bcd_reg       <= bcd_next;
        end
    end

endmodule

`default_nettype wire

### design/acaf_emit.sv
// back part, second half: frame sequencer and result register
`default_nettype none

module acaf_emit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cnv_done,
    input  wire acaf_pkg::bcd_t      cnv_bcd,
    output logic                     cnv_take,
    output logic                     empty,
    input  wire logic                pop,
    output logic [7:0]               out_byte,
    output logic                     last_byte
);

    localparam logic [acaf_pkg::IDX_W-1:0] IDX_LAST = acaf_pkg::IDX_W'(acaf_pkg::FRAME_LEN - 1);

    acaf_pkg::bcd_t                  bcd_reg;
    logic                            active_reg;
    logic [acaf_pkg::IDX_W-1:0]      idx_reg;
    logic                            out_valid_reg;
    logic [7:0]                      out_byte_reg;
    logic                            last_byte_reg;
    logic                            adv;
    logic                            finish;
    logic [7:0]                      byte_c;

    // character for one of the four printed digits; the thousands place folds
    // in the ten-thousands digit, so it is not clamped to a digit
    function automatic logic [7:0] digit_char(
        input logic [acaf_pkg::BCD_W-1:0] b,
        input logic [1:0]                 pos
    );
        logic [7:0] thou;
        logic [7:0] ch;
        thou = {4'b0, b[19:16]};
        case (pos)
            2'd0:    ch = acaf_pkg::CH_ZERO + (thou << 3) + (thou << 1) + {4'b0, b[15:12]};
            2'd1:    ch = acaf_pkg::CH_ZERO + {4'b0, b[11:8]};
            2'd2:    ch = acaf_pkg::CH_ZERO + {4'b0, b[7:4]};
            default: ch = acaf_pkg::CH_ZERO + {4'b0, b[3:0]};
        endcase
        return ch;
    endfunction

    assign adv      = !out_valid_reg || pop;
    assign finish   = active_reg && adv && (idx_reg == IDX_LAST);
    assign cnv_take = cnv_done && (!active_reg || finish);

    assign empty     = !out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_byte_reg;

    always_comb
    begin
        case (idx_reg) inside
            4'd0:          byte_c = acaf_pkg::CH_S;
            [4'd1:4'd4]:   byte_c = digit_char(bcd_reg.steer, 2'(idx_reg - 4'd1));
            4'd5:          byte_c = acaf_pkg::CH_R;
            [4'd6:4'd9]:   byte_c = digit_char(bcd_reg.rev, 2'(idx_reg - 4'd6));
            4'd10:         byte_c = acaf_pkg::CH_A;
            [4'd11:4'd14]: byte_c = digit_char(bcd_reg.fwd, 2'(idx_reg - 4'd11));
            default:       byte_c = acaf_pkg::CH_NL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cnv_take)
            begin
                active_reg <= 1'b1;
                idx_reg    <= '0;
            end
            else
            begin
                if (finish)
                    active_reg <= 1'b0;
                if (active_reg && adv)
                    idx_reg <= idx_reg + acaf_pkg::IDX_W'(1);
            end
            if (adv)
                out_valid_reg <= active_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnv_take)
            bcd_reg <= cnv_bcd;
        if (active_reg && adv)
        begin
            out_byte_reg  <= byte_c;
            last_byte_reg <= (idx_reg == IDX_LAST);
        end
    end

endmodule

`default_nettype wire
